@@ rtl/grid_bilinear_sampler_core_assert.svh @@
// Assertion macros for the sampler RTL, included by gbs_back.
`ifndef GRID_BILINEAR_SAMPLER_CORE_ASSERT_SVH
`define GRID_BILINEAR_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define GBS_CHECK_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sampler assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define GBS_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sampler assertion failed");

`endif

@@ rtl/gbs_pkg.sv @@
// Shared types and constants of the grid bilinear sampler.
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;

  localparam int POS_W     = 20;
  localparam int IDX_W     = 12;
  localparam int VAL_W     = 16;
  localparam int GRAD_W    = 18;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 13'd64;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 13'd64;

  localparam logic signed [VAL_W-1:0]  VAL_MAX  = 16'sh7fff;
  localparam logic signed [VAL_W-1:0]  VAL_MIN  = 16'sh8000;
  localparam logic signed [GRAD_W-1:0] GRAD_MAX = 18'sh1ffff;
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = 18'sh20000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_OUTSIDE = 1'b1
  } status_t;

  // Per-stage control of a word travelling down the pipeline.
  typedef struct packed {
    logic query;
    logic oob;
  } stage_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/gbs_ram.sv @@
// Generic single-write, dual-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

@@ rtl/gbs_front.sv @@
// Front pipeline: input register, cell split, weights and RAM address generation.
`timescale 1ns / 1ps
`default_nettype none
module gbs_front #(
  parameter int GRID_CELLS = 4096,
  parameter int FRAC_BITS  = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic                               op,
  input  logic [gbs_pkg::IDX_W-1:0]          cell_index,
  input  logic signed [gbs_pkg::VAL_W-1:0]   cell_value,
  input  logic [gbs_pkg::POS_W-1:0]          pos_x,
  input  logic [gbs_pkg::POS_W-1:0]          pos_y,
  input  logic [gbs_pkg::DIM_W-1:0]          grid_width,
  input  logic [gbs_pkg::DIM_W-1:0]          grid_height,
  output logic                               ram_we,
  output logic [$clog2(GRID_CELLS)-1:0]      ram_waddr,
  output logic [gbs_pkg::VAL_W-1:0]          ram_wdata,
  output logic [$clog2(GRID_CELLS)-1:0]      addr_00,
  output logic [$clog2(GRID_CELLS)-1:0]      addr_10,
  output logic [$clog2(GRID_CELLS)-1:0]      addr_01,
  output logic [$clog2(GRID_CELLS)-1:0]      addr_11,
  output gbs_pkg::stage_ctrl_t               ctrl,
  output logic [FRAC_BITS-1:0]               frac_x,
  output logic [FRAC_BITS-1:0]               frac_y,
  output logic [2*FRAC_BITS:0]               w00,
  output logic [2*FRAC_BITS:0]               w10,
  output logic [2*FRAC_BITS:0]               w01,
  output logic [2*FRAC_BITS:0]               w11
);
  import gbs_pkg::*;

  localparam int AW     = $clog2(GRID_CELLS);
  localparam int CELL_W = POS_W - FRAC_BITS;
  localparam int ROW_W  = CELL_W + DIM_W;
  localparam int IW     = ROW_W + 1;
  localparam int CW     = (IW + 1 > AW + 1) ? IW + 1 : AW + 1;
  localparam int FR_W   = FRAC_BITS + 1;
  localparam int PW     = 2 * FR_W;
  localparam int WT_W   = 2 * FRAC_BITS + 1;
  localparam logic [FR_W-1:0] ONE = FR_W'(1) << FRAC_BITS;

  // Stage 1 registers.
  logic                    s1_valid;
  op_t                     s1_op;
  logic [IDX_W-1:0]        s1_idx;
  logic [VAL_W-1:0]        s1_val;
  logic [POS_W-1:0]        s1_px;
  logic [POS_W-1:0]        s1_py;

  // Stage 2 registers.
  logic                    s2_valid;
  op_t                     s2_op;
  logic [IDX_W-1:0]        s2_idx;
  logic [VAL_W-1:0]        s2_val;
  logic [ROW_W-1:0]        s2_row;
  logic [CELL_W-1:0]       s2_sx;
  logic                    s2_edge;

  logic [CELL_W-1:0]       sx;
  logic [CELL_W-1:0]       sy;
  logic [FRAC_BITS-1:0]    fx;
  logic [FRAC_BITS-1:0]    fy;
  logic [FR_W-1:0]         wx0;
  logic [FR_W-1:0]         wx1;
  logic [FR_W-1:0]         wy0;
  logic [FR_W-1:0]         wy1;
  logic [PW-1:0]           p00;
  logic [PW-1:0]           p10;
  logic [PW-1:0]           p01;
  logic [PW-1:0]           p11;
  logic [ROW_W-1:0]        row_next;
  logic                    edge_next;
  logic [CW-1:0]           base;
  logic [CW-1:0]           base_r;
  logic [CW-1:0]           base_d;
  logic [CW-1:0]           base_dr;
  logic [CW-1:0]           widx;

  assign sx = s1_px[POS_W-1:FRAC_BITS];
  assign sy = s1_py[POS_W-1:FRAC_BITS];
  assign fx = s1_px[FRAC_BITS-1:0];
  assign fy = s1_py[FRAC_BITS-1:0];

  assign row_next  = ROW_W'(sy) * ROW_W'(grid_width);
  assign edge_next = ((CW'(sx) + CW'(1)) >= CW'(grid_width)) ||
                     ((CW'(sy) + CW'(1)) >= CW'(grid_height));

  assign wx0 = ONE - FR_W'(fx);
  assign wx1 = FR_W'(fx);
  assign wy0 = ONE - FR_W'(fy);
  assign wy1 = FR_W'(fy);
  assign p00 = PW'(wx0) * PW'(wy0);
  assign p10 = PW'(wx1) * PW'(wy0);
  assign p01 = PW'(wx0) * PW'(wy1);
  assign p11 = PW'(wx1) * PW'(wy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op  <= op_t'(op);
      s1_idx <= cell_index;
      s1_val <= cell_value;
      s1_px  <= pos_x;
      s1_py  <= pos_y;
      s2_op   <= s1_op;
      s2_idx  <= s1_idx;
      s2_val  <= s1_val;
      s2_row  <= row_next;
      s2_sx   <= sx;
      s2_edge <= edge_next;
      frac_x  <= fx;
      frac_y  <= fy;
      w00     <= p00[WT_W-1:0];
      w10     <= p10[WT_W-1:0];
      w01     <= p01[WT_W-1:0];
      w11     <= p11[WT_W-1:0];
    end
  end

  // Writes and reads both leave from stage 2, so the RAM sees them in arrival order.
  assign base    = CW'(s2_row) + CW'(s2_sx);
  assign base_r  = base + CW'(1);
  assign base_d  = base + CW'(grid_width);
  assign base_dr = base_d + CW'(1);

  assign addr_00 = base[AW-1:0];
  assign addr_10 = base_r[AW-1:0];
  assign addr_01 = base_d[AW-1:0];
  assign addr_11 = base_dr[AW-1:0];

  assign ctrl.query = s2_valid && (s2_op == OP_QUERY);
  assign ctrl.oob   = s2_edge || (base_dr >= CW'(GRID_CELLS));

  assign widx      = CW'(s2_idx);
  assign ram_we    = adv && s2_valid && (s2_op == OP_WRITE) && (widx < CW'(GRID_CELLS));
  assign ram_waddr = widx[AW-1:0];
  assign ram_wdata = s2_val;

endmodule
`default_nettype wire

@@ rtl/gbs_back.sv @@
// Back pipeline: weighted products, gradient terms, rounding, saturation and output skid.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_bilinear_sampler_core_assert.svh"
module gbs_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  output logic                              adv,
  input  gbs_pkg::stage_ctrl_t              ctrl_in,
  input  logic [FRAC_BITS-1:0]              frac_x,
  input  logic [FRAC_BITS-1:0]              frac_y,
  input  logic [2*FRAC_BITS:0]              w00,
  input  logic [2*FRAC_BITS:0]              w10,
  input  logic [2*FRAC_BITS:0]              w01,
  input  logic [2*FRAC_BITS:0]              w11,
  input  logic signed [gbs_pkg::VAL_W-1:0]  v00,
  input  logic signed [gbs_pkg::VAL_W-1:0]  v10,
  input  logic signed [gbs_pkg::VAL_W-1:0]  v01,
  input  logic signed [gbs_pkg::VAL_W-1:0]  v11,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [gbs_pkg::VAL_W-1:0]  value,
  output logic signed [gbs_pkg::GRAD_W-1:0] grad_x,
  output logic signed [gbs_pkg::GRAD_W-1:0] grad_y,
  output logic                              status
);
  import gbs_pkg::*;

  localparam int WT_W = 2 * FRAC_BITS + 1;
  localparam int PV   = VAL_W + WT_W + 1;
  localparam int SA_W = PV + 2;
  localparam int DW   = VAL_W + 1;
  localparam int FR_W = FRAC_BITS + 1;
  localparam int GPW  = DW + FR_W + 1;
  localparam int GS   = GPW + 1;
  localparam logic [FR_W-1:0]        ONE    = FR_W'(1) << FRAC_BITS;
  localparam logic signed [SA_W-1:0] V_HALF = SA_W'(1) <<< (2 * FRAC_BITS - 1);
  localparam logic signed [SA_W-1:0] V_HI   = SA_W'(VAL_MAX);
  localparam logic signed [SA_W-1:0] V_LO   = SA_W'(VAL_MIN);
  localparam logic signed [GS-1:0]   G_HALF = GS'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [GS-1:0]   G_HI   = GS'(GRAD_MAX);
  localparam logic signed [GS-1:0]   G_LO   = GS'(GRAD_MIN);

  // Stage 3 (read data comes straight from the RAM output registers).
  stage_ctrl_t             s3_ctrl;
  logic [FRAC_BITS-1:0]    s3_fx;
  logic [FRAC_BITS-1:0]    s3_fy;
  logic [WT_W-1:0]         s3_w00;
  logic [WT_W-1:0]         s3_w10;
  logic [WT_W-1:0]         s3_w01;
  logic [WT_W-1:0]         s3_w11;

  // Stage 4.
  stage_ctrl_t             s4_ctrl;
  logic [FRAC_BITS-1:0]    s4_fx;
  logic [FRAC_BITS-1:0]    s4_fy;
  logic signed [PV-1:0]    s4_p00;
  logic signed [PV-1:0]    s4_p10;
  logic signed [PV-1:0]    s4_p01;
  logic signed [PV-1:0]    s4_p11;
  logic signed [DW-1:0]    s4_dx0;
  logic signed [DW-1:0]    s4_dx1;
  logic signed [DW-1:0]    s4_dy0;
  logic signed [DW-1:0]    s4_dy1;

  // Stage 5.
  stage_ctrl_t             s5_ctrl;
  logic signed [SA_W-1:0]  s5_sum_a;
  logic signed [SA_W-1:0]  s5_sum_b;
  logic signed [GPW-1:0]   s5_gx_a;
  logic signed [GPW-1:0]   s5_gx_b;
  logic signed [GPW-1:0]   s5_gy_a;
  logic signed [GPW-1:0]   s5_gy_b;

  // Output register and skid register.
  logic                    ov;
  logic                    kv;
  logic signed [VAL_W-1:0]  o_value;
  logic signed [GRAD_W-1:0] o_gx;
  logic signed [GRAD_W-1:0] o_gy;
  logic                     o_status;
  logic signed [VAL_W-1:0]  k_value;
  logic signed [GRAD_W-1:0] k_gx;
  logic signed [GRAD_W-1:0] k_gy;
  logic                     k_status;

  logic signed [PV-1:0]    p00;
  logic signed [PV-1:0]    p10;
  logic signed [PV-1:0]    p01;
  logic signed [PV-1:0]    p11;
  logic signed [DW-1:0]    dx0;
  logic signed [DW-1:0]    dx1;
  logic signed [DW-1:0]    dy0;
  logic signed [DW-1:0]    dy1;
  logic [FR_W-1:0]         wx0;
  logic [FR_W-1:0]         wy0;
  logic signed [GPW-1:0]   gx_a;
  logic signed [GPW-1:0]   gx_b;
  logic signed [GPW-1:0]   gy_a;
  logic signed [GPW-1:0]   gy_b;
  logic signed [SA_W-1:0]  sum_a;
  logic signed [SA_W-1:0]  sum_b;
  logic signed [SA_W-1:0]  acc;
  logic signed [SA_W-1:0]  acc_q;
  logic signed [GS-1:0]    gx_q;
  logic signed [GS-1:0]    gy_q;
  logic                    res_valid;
  logic signed [VAL_W-1:0]  res_value_next;
  logic signed [GRAD_W-1:0] res_gx_next;
  logic signed [GRAD_W-1:0] res_gy_next;
  logic                     res_status_next;

  // The whole pipeline moves unless the skid register already holds a word.
  assign adv = !kv;

  // Stage 3 math: sample times bilinear weight, and neighbor differences.
  assign p00 = PV'(v00) * PV'($signed({1'b0, s3_w00}));
  assign p10 = PV'(v10) * PV'($signed({1'b0, s3_w10}));
  assign p01 = PV'(v01) * PV'($signed({1'b0, s3_w01}));
  assign p11 = PV'(v11) * PV'($signed({1'b0, s3_w11}));
  assign dx0 = DW'(v10) - DW'(v00);
  assign dx1 = DW'(v11) - DW'(v01);
  assign dy0 = DW'(v01) - DW'(v00);
  assign dy1 = DW'(v11) - DW'(v10);

  // Stage 4 math: gradient terms and half sums of the value.
  assign wx0   = ONE - FR_W'(s4_fx);
  assign wy0   = ONE - FR_W'(s4_fy);
  assign gx_a  = GPW'(s4_dx0) * GPW'($signed({1'b0, wy0}));
  assign gx_b  = GPW'(s4_dx1) * GPW'($signed({1'b0, FR_W'(s4_fy)}));
  assign gy_a  = GPW'(s4_dy0) * GPW'($signed({1'b0, wx0}));
  assign gy_b  = GPW'(s4_dy1) * GPW'($signed({1'b0, FR_W'(s4_fx)}));
  assign sum_a = SA_W'(s4_p00) + SA_W'(s4_p10);
  assign sum_b = SA_W'(s4_p01) + SA_W'(s4_p11);

  // Stage 5 math: round half up (floor after adding a half), then saturate.
  assign acc   = s5_sum_a + s5_sum_b + V_HALF;
  assign acc_q = acc >>> (2 * FRAC_BITS);
  assign gx_q  = (GS'(s5_gx_a) + GS'(s5_gx_b) + G_HALF) >>> FRAC_BITS;
  assign gy_q  = (GS'(s5_gy_a) + GS'(s5_gy_b) + G_HALF) >>> FRAC_BITS;

  assign res_valid = s5_ctrl.query;

  always_comb begin
    if (s5_ctrl.oob) begin
      res_value_next  = '0;
      res_gx_next     = '0;
      res_gy_next     = '0;
      res_status_next = STATUS_OUTSIDE;
    end else begin
      res_value_next  = (acc_q > V_HI) ? VAL_MAX :
                        (acc_q < V_LO) ? VAL_MIN : acc_q[VAL_W-1:0];
      res_gx_next     = (gx_q > G_HI) ? GRAD_MAX :
                        (gx_q < G_LO) ? GRAD_MIN : gx_q[GRAD_W-1:0];
      res_gy_next     = (gy_q > G_HI) ? GRAD_MAX :
                        (gy_q < G_LO) ? GRAD_MIN : gy_q[GRAD_W-1:0];
      res_status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctrl <= '0;
      s4_ctrl <= '0;
      s5_ctrl <= '0;
    end else if (adv) begin
      s3_ctrl <= ctrl_in;
      s4_ctrl <= s3_ctrl;
      s5_ctrl <= s4_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fx    <= frac_x;
      s3_fy    <= frac_y;
      s3_w00   <= w00;
      s3_w10   <= w10;
      s3_w01   <= w01;
      s3_w11   <= w11;
      s4_fx    <= s3_fx;
      s4_fy    <= s3_fy;
      s4_p00   <= p00;
      s4_p10   <= p10;
      s4_p01   <= p01;
      s4_p11   <= p11;
      s4_dx0   <= dx0;
      s4_dx1   <= dx1;
      s4_dy0   <= dy0;
      s4_dy1   <= dy1;
      s5_sum_a <= sum_a;
      s5_sum_b <= sum_b;
      s5_gx_a  <= gx_a;
      s5_gx_b  <= gx_b;
      s5_gy_a  <= gy_a;
      s5_gy_b  <= gy_b;
    end
  end

  // A word arriving while the output word is stalled parks in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      kv <= 1'b0;
    end else if (kv) begin
      if (!out_stall) begin
        kv <= 1'b0;
      end
    end else if (ov && out_stall) begin
      kv <= res_valid;
    end else begin
      ov <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (kv) begin
      if (!out_stall) begin
        o_value  <= k_value;
        o_gx     <= k_gx;
        o_gy     <= k_gy;
        o_status <= k_status;
      end
    end else if (ov && out_stall) begin
      k_value  <= res_value_next;
      k_gx     <= res_gx_next;
      k_gy     <= res_gy_next;
      k_status <= res_status_next;
    end else begin
      o_value  <= res_value_next;
      o_gx     <= res_gx_next;
      o_gy     <= res_gy_next;
      o_status <= res_status_next;
    end
  end

  assign out_valid = ov;
  assign value     = o_value;
  assign grad_x    = o_gx;
  assign grad_y    = o_gy;
  assign status    = o_status;

  `GBS_CHECK_IMPL(skid_implies_out, kv, ov)
  `GBS_CHECK_NEXT(skid_drains, kv && !out_stall, !kv)
  `GBS_CHECK_IMPL(outside_is_zero, ov && (o_status == STATUS_OUTSIDE),
                  (o_value == '0) && (o_gx == '0) && (o_gy == '0))
  `GBS_CHECK_NEXT(frozen_pipe_holds, !adv, $stable(s5_ctrl) && $stable(s5_sum_a))

endmodule
`default_nettype wire

@@ rtl/grid_bilinear_sampler_core.sv @@
// Top level of the grid bilinear sampler: config registers, two grid copies, pipeline.
// Throughput: one word (grid write or query) per cycle while in_stall is low, set by the
// two copies of the grid RAM, each giving two reads per cycle for the four neighbors of a
// query. A query result is registered through stages 1 to 5 and the output register.
// Reset clears the pipeline and sets grid_width and grid_height to 64; grid contents stay
// undefined until written and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none
module grid_bilinear_sampler_core #(
  parameter int GRID_CELLS = 4096,
  parameter int FRAC_BITS  = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbs_pkg::DIM_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               op,
  input  logic [gbs_pkg::IDX_W-1:0]          cell_index,
  input  logic signed [gbs_pkg::VAL_W-1:0]   cell_value,
  input  logic [gbs_pkg::POS_W-1:0]          pos_x,
  input  logic [gbs_pkg::POS_W-1:0]          pos_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [gbs_pkg::VAL_W-1:0]   value,
  output logic signed [gbs_pkg::GRAD_W-1:0]  grad_x,
  output logic signed [gbs_pkg::GRAD_W-1:0]  grad_y,
  output logic                               status
);
  import gbs_pkg::*;

  localparam int AW   = $clog2(GRID_CELLS);
  localparam int WT_W = 2 * FRAC_BITS + 1;

  logic [DIM_W-1:0]      grid_width;
  logic [DIM_W-1:0]      grid_height;

  logic                  adv;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VAL_W-1:0]      ram_wdata;
  logic [AW-1:0]         addr_00;
  logic [AW-1:0]         addr_10;
  logic [AW-1:0]         addr_01;
  logic [AW-1:0]         addr_11;
  stage_ctrl_t           ctrl;
  logic [FRAC_BITS-1:0]  frac_x;
  logic [FRAC_BITS-1:0]  frac_y;
  logic [WT_W-1:0]       w00;
  logic [WT_W-1:0]       w10;
  logic [WT_W-1:0]       w01;
  logic [WT_W-1:0]       w11;
  logic [VAL_W-1:0]      rd_00;
  logic [VAL_W-1:0]      rd_10;
  logic [VAL_W-1:0]      rd_01;
  logic [VAL_W-1:0]      rd_11;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !adv;

  gbs_front #(
    .GRID_CELLS (GRID_CELLS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .op          (op),
    .cell_index  (cell_index),
    .cell_value  (cell_value),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .addr_00     (addr_00),
    .addr_10     (addr_10),
    .addr_01     (addr_01),
    .addr_11     (addr_11),
    .ctrl        (ctrl),
    .frac_x      (frac_x),
    .frac_y      (frac_y),
    .w00         (w00),
    .w10         (w10),
    .w01         (w01),
    .w11         (w11)
  );

  // Both copies take every write; one serves the lower row pair, the other the upper.
  gbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (GRID_CELLS)
  ) u_ram_lo (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (adv),
    .raddr_a (addr_00),
    .raddr_b (addr_10),
    .rdata_a (rd_00),
    .rdata_b (rd_10)
  );

  gbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (GRID_CELLS)
  ) u_ram_hi (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (adv),
    .raddr_a (addr_01),
    .raddr_b (addr_11),
    .rdata_a (rd_01),
    .rdata_b (rd_11)
  );

  gbs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctrl_in   (ctrl),
    .frac_x    (frac_x),
    .frac_y    (frac_y),
    .w00       (w00),
    .w10       (w10),
    .w01       (w01),
    .w11       (w11),
    .v00       ($signed(rd_00)),
    .v10       ($signed(rd_10)),
    .v01       ($signed(rd_01)),
    .v11       ($signed(rd_11)),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .value     (value),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .status    (status)
  );

endmodule
`default_nettype wire
